// ===== design/haversine_distance_defines.svh =====
// Assertion macros for the haversine distance block.
// Depends on a clock named clock and a synchronous active-high reset named reset.
`ifndef HAVERSINE_DISTANCE_DEFINES_SVH
`define HAVERSINE_DISTANCE_DEFINES_SVH
`ifndef SYNTHESIS
`define HVD_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("haversine_distance: check failed");
`define HVD_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("haversine_distance: check failed");
`else
`define HVD_ASSERT_IMP(lbl, ante, cons)
`define HVD_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== design/hvd_pkg.sv =====
// Shared constants, types and the arctangent table for the haversine block.
// No dependencies.
package hvd_pkg;

   localparam int CORDIC_STEPS = 24;
   localparam int SQRT_BITS    = 31;
   localparam int LATENCY      = 2 * CORDIC_STEPS + SQRT_BITS + 9;

   typedef logic signed [33:0] hvd_xy_type;
   typedef logic signed [32:0] hvd_ang_type;
   typedef logic signed [31:0] hvd_q30_type;
   typedef logic        [61:0] hvd_rem_type;
   typedef logic        [30:0] hvd_root_type;

   localparam hvd_xy_type  CORDIC_GAIN = 34'sd652032874;
   localparam hvd_q30_type Q30_ONE     = 32'sd1073741824;
   localparam hvd_q30_type Q30_HALF    = 32'sd536870912;
   localparam hvd_ang_type Q30_HALF_PI = 33'sd1686629713;
   localparam logic [24:0] DEG_TO_RAD  = 25'd18740330;
   localparam logic signed [27:0] DEG180_Q17 = 28'sd23592960;
   localparam logic signed [27:0] DEG90_Q17  = 28'sd11796480;
   localparam logic signed [27:0] DEG360_Q17 = 28'sd47185920;
   localparam logic [15:0] RADIUS_RESET = 16'd6371;

   function automatic hvd_ang_type atan_entry(input logic [4:0] idx);
      logic [29:0] v;
      case (idx)
         5'd0:  v = 30'd843314856;
         5'd1:  v = 30'd497837829;
         5'd2:  v = 30'd263043836;
         5'd3:  v = 30'd133525158;
         5'd4:  v = 30'd67021686;
         5'd5:  v = 30'd33543515;
         5'd6:  v = 30'd16775850;
         5'd7:  v = 30'd8388437;
         5'd8:  v = 30'd4194282;
         5'd9:  v = 30'd2097149;
         5'd10: v = 30'd1048575;
         5'd11: v = 30'd524287;
         5'd12: v = 30'd262143;
         5'd13: v = 30'd131071;
         5'd14: v = 30'd65535;
         5'd15: v = 30'd32767;
         5'd16: v = 30'd16383;
         5'd17: v = 30'd8191;
         5'd18: v = 30'd4095;
         5'd19: v = 30'd2047;
         5'd20: v = 30'd1023;
         5'd21: v = 30'd511;
         5'd22: v = 30'd255;
         5'd23: v = 30'd127;
         5'd24: v = 30'd63;
         5'd25: v = 30'd31;
         5'd26: v = 30'd15;
         5'd27: v = 30'd8;
         5'd28: v = 30'd4;
         5'd29: v = 30'd2;
         5'd30: v = 30'd1;
         default: v = 30'd0;
      endcase
      return hvd_ang_type'({3'b000, v});
   endfunction

endpackage

// ===== design/haversine_distance.sv =====
// Haversine great-circle distance, fully pipelined chain of CORDIC and root cells.
// One item accepted every cycle.
// busy never rises: each unrolled cell takes a new item per clock, no stall possible.
// Synchronous reset clears the valid line and restores the radius to 6371 km.
// Depends on hvd_pkg, hvd_cordic_cell, hvd_sqrt_cell and haversine_distance_defines.svh.
`include "haversine_distance_defines.svh"
module haversine_distance
   import hvd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [23:0] req_start_latitude,
   input  logic signed [24:0] req_start_longitude,
   input  logic signed [23:0] req_end_latitude,
   input  logic signed [24:0] req_end_longitude,
   output logic               rsp_valid,
   output logic        [17:0] rsp_distance_km,
   input  logic               csr_wr_en,
   input  logic        [15:0] csr_wr_data
);
   // Lane order: 0 = first latitude, 1 = second latitude,
   // 2 = half latitude difference, 3 = half longitude difference.
   localparam int LANES = 4;

   logic [15:0]        radius_ff;
   logic [LATENCY-1:0] vld_ff;

   logic signed [23:0] lat1_ff, lat2_ff;
   logic signed [24:0] lon1_ff, lon2_ff;
   logic signed [27:0] deg [LANES];

   logic [23:0]  mag_ff  [LANES];
   logic         negz_ff [LANES];
   logic         negr_ff [LANES];
   hvd_ang_type  z0_ff   [LANES];
   logic         neg0_ff [LANES];

   hvd_xy_type  cx [LANES][CORDIC_STEPS+1];
   hvd_xy_type  cy [LANES][CORDIC_STEPS+1];
   hvd_ang_type cz [LANES][CORDIC_STEPS+1];
   logic        ct [LANES][CORDIC_STEPS+1];

   hvd_q30_type trig_ff [LANES];
   hvd_q30_type sh2_ff, sw2_ff, cc_ff, sh2d_ff, ccs_ff;
   logic [30:0] a_ff;

   hvd_rem_type  srem [2][SQRT_BITS+1];
   hvd_root_type sroot[2][SQRT_BITS+1];

   hvd_xy_type  ax [CORDIC_STEPS+1];
   hvd_xy_type  ay [CORDIC_STEPS+1];
   hvd_ang_type az [CORDIC_STEPS+1];
   logic        at [CORDIC_STEPS+1];

   logic [46:0] prod_ff;
   logic [17:0] dist_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
         vld_ff    <= '0;
      end else begin
         if (csr_wr_en) begin
            radius_ff <= csr_wr_data;
         end
         // shift the valid line on each clock, inserting each accepted item
         vld_ff <= {vld_ff[LATENCY-2:0], start & ~busy};
      end
   end

   // Hold the accepted coordinates.
   always_ff @(posedge clock) begin
      if (start) begin
         lat1_ff <= req_start_latitude;
         lon1_ff <= req_start_longitude;
         lat2_ff <= req_end_latitude;
         lon2_ff <= req_end_longitude;
      end
   end

   // Degrees in Q17: doubled latitudes, and plain differences that read as halves.
   always_comb begin
      deg[0] = {{3{lat1_ff[23]}}, lat1_ff, 1'b0};
      deg[1] = {{3{lat2_ff[23]}}, lat2_ff, 1'b0};
      deg[2] = 28'(lat2_ff) - 28'(lat1_ff);
      deg[3] = 28'(lon2_ff) - 28'(lon1_ff);
   end

   // Wrap into one turn, fold into the right half-plane, and take the magnitude.
   always_ff @(posedge clock) begin
      logic signed [27:0] d;
      logic               n;
      for (int i = 0; i < LANES; i++) begin
         d = deg[i];
         n = 1'b0;
         if (d > DEG180_Q17) begin
            d = d - DEG360_Q17;
         end else if (d < -DEG180_Q17) begin
            d = d + DEG360_Q17;
         end
         if (d > DEG90_Q17) begin
            d = d - DEG180_Q17;
            n = 1'b1;
         end else if (d < -DEG90_Q17) begin
            d = d + DEG180_Q17;
            n = 1'b1;
         end
         negz_ff[i] <= d[27];
         negr_ff[i] <= n;
         mag_ff[i]  <= d[27] ? 24'(-d) : 24'(d);
      end
   end

   // Degrees to Q30 radians, rounding half away from zero.
   always_ff @(posedge clock) begin
      logic [48:0] p;
      logic [31:0] r;
      for (int i = 0; i < LANES; i++) begin
         p = 49'(mag_ff[i]) * 49'(DEG_TO_RAD) + 49'd65536;
         r = p[48:17];
         z0_ff[i]   <= negz_ff[i] ? -hvd_ang_type'(r) : hvd_ang_type'(r);
         neg0_ff[i] <= negr_ff[i];
      end
   end

   // Row of rotation cells per lane.
   for (genvar l = 0; l < LANES; l++) begin : g_lane
      assign cx[l][0] = CORDIC_GAIN;
      assign cy[l][0] = '0;
      assign cz[l][0] = z0_ff[l];
      assign ct[l][0] = neg0_ff[l];
      for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_step
         hvd_cordic_cell u_cell (
            .clock     (clock),
            .vectoring (1'b0),
            .shift     (5'(s)),
            .angle     (atan_entry(5'(s))),
            .src_x     (cx[l][s]),
            .src_y     (cy[l][s]),
            .src_z     (cz[l][s]),
            .src_tag   (ct[l][s]),
            .x_ff      (cx[l][s+1]),
            .y_ff      (cy[l][s+1]),
            .z_ff      (cz[l][s+1]),
            .tag_ff    (ct[l][s+1])
         );
      end
   end

   // Clamp to unit range and restore the sign dropped by the half-turn fold.
   // Latitude lanes keep the cosine, difference lanes the sine.
   always_ff @(posedge clock) begin
      hvd_xy_type v;
      hvd_q30_type c;
      for (int i = 0; i < LANES; i++) begin
         v = (i < 2) ? cx[i][CORDIC_STEPS] : cy[i][CORDIC_STEPS];
         if (v > hvd_xy_type'(Q30_ONE)) begin
            c = Q30_ONE;
         end else if (v < -hvd_xy_type'(Q30_ONE)) begin
            c = -Q30_ONE;
         end else begin
            c = 32'(v);
         end
         trig_ff[i] <= ct[i][CORDIC_STEPS] ? -c : c;
      end
   end

   function automatic hvd_q30_type round_q30(input hvd_q30_type p, input hvd_q30_type q);
      logic signed [63:0] m;
      m = 64'(p) * 64'(q) + 64'(Q30_HALF);
      return 32'(m >>> 30);
   endfunction

   always_ff @(posedge clock) begin
      sh2_ff <= round_q30(trig_ff[2], trig_ff[2]);
      sw2_ff <= round_q30(trig_ff[3], trig_ff[3]);
      cc_ff  <= round_q30(trig_ff[0], trig_ff[1]);
   end

   always_ff @(posedge clock) begin
      ccs_ff  <= round_q30(cc_ff, sw2_ff);
      sh2d_ff <= sh2_ff;
   end

   // Sum and saturate a to [0, 1].
   always_ff @(posedge clock) begin
      logic signed [32:0] s;
      s = 33'(sh2d_ff) + 33'(ccs_ff);
      if (s[32]) begin
         a_ff <= '0;
      end else if (s > 33'(Q30_ONE)) begin
         a_ff <= 31'(Q30_ONE);
      end else begin
         a_ff <= 31'(s);
      end
   end

   // Two root chains: sqrt(a) and sqrt(1 - a), both scaled up by 2^30.
   assign srem[0][0]  = {1'b0, a_ff, 30'd0};
   assign srem[1][0]  = {1'b0, 31'(Q30_ONE) - a_ff, 30'd0};
   assign sroot[0][0] = '0;
   assign sroot[1][0] = '0;
   for (genvar r = 0; r < 2; r++) begin : g_root
      for (genvar b = 0; b < SQRT_BITS; b++) begin : g_bit
         hvd_sqrt_cell u_cell (
            .clock    (clock),
            .bit_pos  (5'(SQRT_BITS - 1 - b)),
            .src_rem  (srem[r][b]),
            .src_root (sroot[r][b]),
            .rem_ff   (srem[r][b+1]),
            .root_ff  (sroot[r][b+1])
         );
      end
   end

   // Vectoring row for atan2(sqrt(a), sqrt(1 - a)).
   assign ax[0] = hvd_xy_type'(sroot[1][SQRT_BITS]);
   assign ay[0] = hvd_xy_type'(sroot[0][SQRT_BITS]);
   assign az[0] = '0;
   assign at[0] = 1'b0;
   for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_atan
      hvd_cordic_cell u_cell (
         .clock     (clock),
         .vectoring (1'b1),
         .shift     (5'(s)),
         .angle     (atan_entry(5'(s))),
         .src_x     (ax[s]),
         .src_y     (ay[s]),
         .src_z     (az[s]),
         .src_tag   (at[s]),
         .x_ff      (ax[s+1]),
         .y_ff      (ay[s+1]),
         .z_ff      (az[s+1]),
         .tag_ff    (at[s+1])
      );
   end

   // Clamp the central half-angle to [0, pi/2] and scale by the radius.
   always_ff @(posedge clock) begin
      hvd_ang_type zc;
      if (az[CORDIC_STEPS][32]) begin
         zc = '0;
      end else if (az[CORDIC_STEPS] > Q30_HALF_PI) begin
         zc = Q30_HALF_PI;
      end else begin
         zc = az[CORDIC_STEPS];
      end
      prod_ff <= 47'(radius_ff) * 47'(zc[30:0]);
   end

   // Twice the angle in Q30 is the product over 2^29; it always fits 18 bits.
   always_ff @(posedge clock) begin
      dist_ff <= prod_ff[46:29];
   end

   assign rsp_valid       = vld_ff[LATENCY-1];
   assign rsp_distance_km = dist_ff;

   `HVD_ASSERT_IMP(a_in_range, vld_ff[CORDIC_STEPS+6], a_ff <= 31'(Q30_ONE))
   `HVD_ASSERT_IMP(rsp_from_req, rsp_valid, $past(start, LATENCY))
   `HVD_ASSERT_IMP(dist_bound, rsp_valid, rsp_distance_km <= 18'd205884)
   `HVD_ASSERT_NXT(zero_radius, vld_ff[LATENCY-2] && radius_ff == 16'd0,
                   rsp_distance_km == 18'd0)
endmodule

// ===== design/hvd_cordic_cell.sv =====
// One CORDIC micro-rotation with its output register, rotation or vectoring.
// Depends on hvd_pkg.
module hvd_cordic_cell
   import hvd_pkg::*;
(
   input  logic        clock,
   input  logic        vectoring,
   input  logic [4:0]  shift,
   input  hvd_ang_type angle,
   input  hvd_xy_type  src_x,
   input  hvd_xy_type  src_y,
   input  hvd_ang_type src_z,
   input  logic        src_tag,
   output hvd_xy_type  x_ff,
   output hvd_xy_type  y_ff,
   output hvd_ang_type z_ff,
   output logic        tag_ff
);
   hvd_xy_type  dx, dy, x_in, y_in;
   hvd_ang_type z_in;
   logic        dir;

   always_comb begin
      dx  = src_y >>> shift;
      dy  = src_x >>> shift;
      // rotate towards zero angle, or towards the x axis when vectoring
      dir = vectoring ? src_y[$bits(hvd_xy_type)-1] : ~src_z[$bits(hvd_ang_type)-1];
      if (dir) begin
         x_in = src_x - dx;
         y_in = src_y + dy;
         z_in = src_z - angle;
      end else begin
         x_in = src_x + dx;
         y_in = src_y - dy;
         z_in = src_z + angle;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      tag_ff <= src_tag;
   end
endmodule

// ===== design/hvd_sqrt_cell.sv =====
// One bit of a restoring integer square root, registered.
// Depends on hvd_pkg.
module hvd_sqrt_cell
   import hvd_pkg::*;
(
   input  logic         clock,
   input  logic [4:0]   bit_pos,
   input  hvd_rem_type  src_rem,
   input  hvd_root_type src_root,
   output hvd_rem_type  rem_ff,
   output hvd_root_type root_ff
);
   hvd_rem_type  trial, rem_in;
   hvd_root_type root_in;

   always_comb begin
      // (root + 2^k)^2 - root^2
      trial = (hvd_rem_type'(src_root) << (bit_pos + 5'd1))
            | (hvd_rem_type'(1) << {bit_pos, 1'b0});
      if (src_rem >= trial) begin
         rem_in  = src_rem - trial;
         root_in = src_root | (hvd_root_type'(1) << bit_pos);
      end else begin
         rem_in  = src_rem;
         root_in = src_root;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end
endmodule

// ===== tb/haversine_distance_checker.sv =====
// Scoreboard for the haversine distance block: predicts each distance from the accepted
// point pair and the current radius, then compares. Depends on hvd_pkg for constants only.
module haversine_distance_checker
   import hvd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic signed [23:0] req_start_latitude,
   input  logic signed [24:0] req_start_longitude,
   input  logic signed [23:0] req_end_latitude,
   input  logic signed [24:0] req_end_longitude,
   input  logic               rsp_valid,
   input  logic        [17:0] rsp_distance_km,
   input  logic               csr_wr_en,
   input  logic        [15:0] csr_wr_data,
   output int                 fail_count,
   output int                 backlog,
   output int                 items_seen,
   output int                 results_seen
);

   localparam longint ONE_Q30   = 64'sd1073741824;
   localparam longint HALF_PI   = 64'sd1686629713;
   localparam longint GAIN_Q30  = 64'sd652032874;
   localparam longint RAD_SCALE = 64'sd18740330;
   localparam longint D90       = 64'sd11796480;
   localparam longint D180      = 64'sd23592960;
   localparam longint D360      = 64'sd47185920;
   localparam longint DIST_MAX  = 64'sd262143;

   localparam longint ARCTAN [32] = '{
      843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
      16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
      65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31, 15,
      8, 4, 2, 1, 0};

   logic [15:0] radius_km;
   logic [17:0] distance_queue[$];

   function automatic longint fix_q30(input longint p);
      return (p + (64'sd1 <<< 29)) >>> 30;
   endfunction

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // Sine and cosine of an angle in degrees with 17 fraction bits.
   function automatic void sine_cosine(input longint deg, output longint s, output longint c);
      bit     flip;
      longint mag, z, x, y, dx, dy;
      flip = 1'b0;
      x = GAIN_Q30;
      y = 0;
      if (deg > D180) deg -= D360;
      else if (deg < -D180) deg += D360;
      if (deg > D90) begin
         deg -= D180;
         flip = 1'b1;
      end else if (deg < -D90) begin
         deg += D180;
         flip = 1'b1;
      end
      mag = deg < 0 ? -deg : deg;
      z = (mag * RAD_SCALE + (64'sd1 <<< 16)) >>> 17;
      if (deg < 0) z = -z;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= ARCTAN[i];
         end else begin
            x += dx; y -= dy; z += ARCTAN[i];
         end
      end
      x = clip(x, -ONE_Q30, ONE_Q30);
      y = clip(y, -ONE_Q30, ONE_Q30);
      s = flip ? -y : y;
      c = flip ? -x : x;
   endfunction

   function automatic longint floor_root(input longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return longint'(r);
   endfunction

   function automatic longint arc_angle(input longint y, input longint x);
      longint z, dx, dy;
      z = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += ARCTAN[i];
         end else begin
            x -= dx; y += dy; z -= ARCTAN[i];
         end
      end
      return clip(z, 0, HALF_PI);
   endfunction

   function automatic logic [17:0] great_circle_km(
      input logic signed [23:0] lat_a, input logic signed [24:0] lon_a,
      input logic signed [23:0] lat_b, input logic signed [24:0] lon_b,
      input logic [15:0] rad);
      longint s1, c1, s2, c2, sh, ch, sw, cw, hav, z, d;
      sine_cosine(longint'(lat_a) * 2, s1, c1);
      sine_cosine(longint'(lat_b) * 2, s2, c2);
      // a Q16 difference read as Q17 is already the half angle
      sine_cosine(longint'(lat_b) - longint'(lat_a), sh, ch);
      sine_cosine(longint'(lon_b) - longint'(lon_a), sw, cw);
      hav = fix_q30(sh * sh) + fix_q30(fix_q30(c1 * c2) * fix_q30(sw * sw));
      hav = clip(hav, 0, ONE_Q30);
      z = arc_angle(floor_root(hav <<< 30), floor_root((ONE_Q30 - hav) <<< 30));
      d = (longint'({48'd0, rad}) * z) >>> 29;
      if (d > DIST_MAX) d = DIST_MAX;
      return d[17:0];
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] distance mismatch: %s", $realtime, what);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      backlog = 0;
      items_seen = 0;
      results_seen = 0;
      radius_km = RADIUS_RESET;
   end

   always @(posedge clock) begin
      logic [17:0] want;
      if (reset) begin
         radius_km = RADIUS_RESET;
      end else begin
         if (rsp_valid) begin
            results_seen++;
            if (distance_queue.size() == 0) begin
               report_mismatch($sformatf("unexpected result %0d", rsp_distance_km));
            end else begin
               want = distance_queue.pop_front();
               if (rsp_distance_km !== want)
                  report_mismatch($sformatf("distance_km got %0d want %0d",
                                            rsp_distance_km, want));
            end
         end
         if (start && !busy) begin
            items_seen++;
            distance_queue.push_back(great_circle_km(req_start_latitude,
               req_start_longitude, req_end_latitude, req_end_longitude, radius_km));
         end
         if (csr_wr_en) radius_km = csr_wr_data;
      end
      backlog = distance_queue.size();
   end

endmodule

// ===== tb/tb.sv =====
// Top of the haversine distance testbench: clock, reset, stimulus, watchdog and verdict.
// Depends on hvd_pkg, haversine_distance and haversine_distance_checker.
module tb
   import hvd_pkg::*;
;

   localparam int IDLE_LIMIT   = 5000;
   localparam int RANDOM_ITEMS = 600;
   localparam int LAT_MAX      = 5898240;   // 90 degrees
   localparam int LON_MAX      = 11796480;  // 180 degrees

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [23:0] req_start_latitude = '0;
   logic signed [24:0] req_start_longitude = '0;
   logic signed [23:0] req_end_latitude = '0;
   logic signed [24:0] req_end_longitude = '0;
   logic               rsp_valid;
   logic        [17:0] rsp_distance_km;
   logic               csr_wr_en = 1'b0;
   logic        [15:0] csr_wr_data = '0;

   int fail_count, backlog, items_seen, results_seen;
   int idle_cycles = 0;
   int burst_left = 0;

   haversine_distance dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_start_latitude  (req_start_latitude),
      .req_start_longitude (req_start_longitude),
      .req_end_latitude    (req_end_latitude),
      .req_end_longitude   (req_end_longitude),
      .rsp_valid           (rsp_valid),
      .rsp_distance_km     (rsp_distance_km),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data)
   );

   haversine_distance_checker scoreboard (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_start_latitude  (req_start_latitude),
      .req_start_longitude (req_start_longitude),
      .req_end_latitude    (req_end_latitude),
      .req_end_longitude   (req_end_longitude),
      .rsp_valid           (rsp_valid),
      .rsp_distance_km     (rsp_distance_km),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .fail_count          (fail_count),
      .backlog             (backlog),
      .items_seen          (items_seen),
      .results_seen        (results_seen)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Watchdog: any accepted item or result counts as progress.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no progress for %0d cycles", IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Present one point pair and hold it until the block takes it. Between bursts,
   // usually drop start for a random gap so gaps land on every phase of the pipeline.
   task automatic send_pair(input logic signed [23:0] lat_a, input logic signed [24:0] lon_a,
                            input logic signed [23:0] lat_b, input logic signed [24:0] lon_b);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      start               <= 1'b1;
      req_start_latitude  <= lat_a;
      req_start_longitude <= lon_a;
      req_end_latitude    <= lat_b;
      req_end_longitude   <= lon_b;
      // busy is settled by the falling edge; the item goes in on the next rising one
      forever begin
         @(negedge clock);
         if (!busy) begin
            @(posedge clock);
            break;
         end
         @(posedge clock);
      end
   endtask

   // Let the pipeline drain, then write the radius while nothing is in flight.
   task automatic set_radius(input logic [15:0] km);
      start <= 1'b0;
      @(posedge clock);
      while (backlog != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= km;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly legal coordinates; now and then any bit pattern the port can carry.
   function automatic logic signed [23:0] pick_lat();
      if ($urandom_range(0, 4) == 0) return 24'($urandom);
      return 24'($urandom_range(0, 2 * LAT_MAX) - LAT_MAX);
   endfunction

   function automatic logic signed [24:0] pick_lon();
      if ($urandom_range(0, 4) == 0) return 25'($urandom);
      return 25'($urandom_range(0, 2 * LON_MAX) - LON_MAX);
   endfunction

   task automatic random_batch(input int count);
      logic signed [23:0] la;
      logic signed [24:0] lo;
      for (int i = 0; i < count; i++) begin
         la = pick_lat();
         lo = pick_lon();
         case ($urandom_range(0, 9))
            0: send_pair(la, lo, la, lo);                    // same point
            1: send_pair(la, lo, -la, lo + 25'(LON_MAX));    // near antipode
            default: send_pair(la, lo, pick_lat(), pick_lon());
         endcase
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed cases at the reset radius.
      send_pair(0, 0, 0, 0);
      send_pair(LAT_MAX, 0, LAT_MAX, LON_MAX);              // pole to pole on same point
      send_pair(0, 0, 0, LON_MAX);                          // antipodes on the equator
      send_pair(LAT_MAX, 0, -LAT_MAX, 0);                   // pole to pole
      send_pair(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
      send_pair(0, -LON_MAX, 0, LON_MAX);                   // same meridian either side
      send_pair(24'sh7FFFFF, 25'sh0FFFFFF, 24'sh800000, 25'sh1000000);
      send_pair(24'sh800000, 25'sh1000000, 24'sh7FFFFF, 25'sh0FFFFFF);
      send_pair(24'sh7FFFFF, 25'sh1000000, 24'sh7FFFFF, 25'sh1000000);
      send_pair(24'sh800000, 0, 0, 25'sh0FFFFFF);
      send_pair(LAT_MAX + 65536, 0, -LAT_MAX - 65536, 0);   // latitudes past the poles
      send_pair(0, LON_MAX + 655360, 0, -LON_MAX - 655360); // longitudes past 180
      send_pair(3342336, 0, 3342336, 1);                    // one LSB apart
      send_pair(1, 0, 0, 0);
      send_pair(-2949120, 2949120, 2949120, -2949120);
      random_batch(RANDOM_ITEMS / 3);

      // Largest radius: the widest distances the field carries.
      set_radius(16'hFFFF);
      send_pair(0, 0, 0, LON_MAX);
      send_pair(LAT_MAX, 0, -LAT_MAX, 0);
      random_batch(RANDOM_ITEMS / 6);

      // Smallest legal radius, then zero, which must give zero everywhere.
      set_radius(16'd1);
      send_pair(0, 0, 0, LON_MAX);
      random_batch(RANDOM_ITEMS / 12);
      set_radius(16'd0);
      send_pair(0, 0, 0, LON_MAX);
      random_batch(RANDOM_ITEMS / 12);

      set_radius(16'($urandom_range(2, 65534)));
      random_batch(RANDOM_ITEMS / 6);
      set_radius(16'd6371);
      random_batch(RANDOM_ITEMS / 6);

      start <= 1'b0;
      @(posedge clock);
      while (backlog != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);

      $display("covered %0d point pairs, %0d distances, radius reset/max/1/0/random/reset",
               items_seen, results_seen);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/hvd_pkg.sv
design/hvd_cordic_cell.sv
design/hvd_sqrt_cell.sv
design/haversine_distance.sv
tb/haversine_distance_checker.sv
tb/tb.sv
